### rtl/hrr_pkg.sv
// ----------------------------------------------------------------------------
// hrr_pkg
// shared types, character codes and record layout for the hex record receiver
// ----------------------------------------------------------------------------
package hrr_pkg;

   // largest data length before a record is flagged too long
   localparam logic [7:0] MAX_DATA = 8'd16;

   // ascii codes
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] DIGIT_TEN    = 8'd10;
   localparam logic [7:0] DIGIT_BAD    = 8'hFF;

   // byte positions inside a record
   localparam int unsigned POS_W = 9;
   localparam logic [POS_W-1:0] POS_COUNT   = 9'd0;
   localparam logic [POS_W-1:0] POS_ADDR_HI = 9'd1;
   localparam logic [POS_W-1:0] POS_ADDR_LO = 9'd2;
   localparam logic [POS_W-1:0] POS_TYPE    = 9'd3;
   localparam logic [POS_W-1:0] POS_DATA    = 9'd4;

   // result kinds
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [15:0] byte_address;
      logic [7:0]  data_byte;
      logic [7:0]  record_type;
      logic [7:0]  byte_count;
      logic        checksum_ok;
      logic        too_long;
   } rsp_word_type;

   // hex digit value, anything else decodes to all ones
   function automatic logic [7:0] digit_value(input logic [7:0] c);
      logic [7:0] v;
      v = DIGIT_BAD;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         v = c - CHAR_ZERO;
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         v = c - CHAR_LOWER_A + DIGIT_TEN;
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         v = c - CHAR_UPPER_A + DIGIT_TEN;
      end
      return v;
   endfunction

endpackage

### rtl/hrr_req_if.sv
// ----------------------------------------------------------------------------
// hrr_req_if
// character channel into the hex record receiver, valid/ready handshake
// ----------------------------------------------------------------------------
interface hrr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;

   modport source (output valid, output character, input ready);
   modport sink   (input valid, input character, output ready);
endinterface

### rtl/hrr_rsp_if.sv
// ----------------------------------------------------------------------------
// hrr_rsp_if
// result channel out of the hex record receiver, valid/ready handshake
// ----------------------------------------------------------------------------
interface hrr_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [15:0] byte_address;
   logic [7:0]  data_byte;
   logic [7:0]  record_type;
   logic [7:0]  byte_count;
   logic        checksum_ok;
   logic        too_long;

   modport source (output valid, output kind, output byte_address, output data_byte,
                   output record_type, output byte_count, output checksum_ok,
                   output too_long, input ready);
   modport sink   (input valid, input kind, input byte_address, input data_byte,
                   input record_type, input byte_count, input checksum_ok,
                   input too_long, output ready);
endinterface

### rtl/hex_record_receiver_top.sv
// ----------------------------------------------------------------------------
// hex_record_receiver_top
// decodes intel hex records one ascii character per word
// ----------------------------------------------------------------------------
// usage
//   req_if carries one received character per word. while idle a colon opens
//   a record and every other character is dropped. inside a record each pair
//   of characters is one byte: count, address high, address low, type, data
//   bytes, checksum.
//   rsp_if carries a data word (kind 0) for every data byte with its address,
//   and one end word (kind 1) after the checksum with type, count, checksum
//   status and a too_long flag for counts above MAX_DATA.
//   result path: a character waits in the input register, and its decode loads
//   the result register once that register is free, where the result is offered.
//   throughput: one character per cycle while the result sink does not stall,
//   set by the single decode stage between the input and result registers.
//   reset (synchronous) returns the decoder to idle and empties both
//   registers. when the result sink stalls, a held result blocks the decode
//   stage, the input register fills and req_if.ready then drops.
// ----------------------------------------------------------------------------
module hex_record_receiver_top (
   input  logic      clock,
   input  logic      reset,
   hrr_req_if.sink   req_if,
   hrr_rsp_if.source rsp_if
);
   import hrr_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff, in_char_in;

   // decoder state
   logic             in_record_ff, in_record_in;
   logic             low_next_ff, low_next_in;
   logic [3:0]       high_nibble_ff, high_nibble_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       length_ff, length_in;
   logic [15:0]      address_ff, address_in;
   logic [7:0]       type_ff, type_in;
   logic [7:0]       sum_ff, sum_in;

   // result register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic             out_free;   // result register can take a new word
   logic             fire;       // decode the held character this cycle
   logic             emit;       // decode produces a result word
   logic             req_take;
   logic [7:0]       digit;
   logic [7:0]       byte_val;
   logic [POS_W-1:0] last_pos;
   logic [POS_W-1:0] data_offset;

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign fire     = in_valid_ff && out_free;
   assign req_if.ready = !in_valid_ff || out_free;
   assign req_take = req_if.valid && req_if.ready;

   // decode stage
   always_comb begin
      in_record_in   = in_record_ff;
      low_next_in    = low_next_ff;
      high_nibble_in = high_nibble_ff;
      pos_in         = pos_ff;
      length_in      = length_ff;
      address_in     = address_ff;
      type_in        = type_ff;
      sum_in         = sum_ff;
      emit           = 1'b0;
      rsp_word_in    = '0;
      digit          = digit_value(in_char_ff);
      byte_val       = {high_nibble_ff, 4'b0000} | digit;
      last_pos       = {1'b0, length_ff} + POS_DATA;
      data_offset    = pos_ff - POS_DATA;

      if (fire) begin
         if (!in_record_ff) begin
            // hunt for the start code
            if (in_char_ff == CHAR_COLON) begin
               in_record_in = 1'b1;
               low_next_in  = 1'b0;
               pos_in       = POS_COUNT;
               sum_in       = '0;
            end
         end else if (!low_next_ff) begin
            high_nibble_in = digit[3:0];
            low_next_in    = 1'b1;
         end else begin
            low_next_in = 1'b0;
            if (pos_ff >= POS_DATA && pos_ff == last_pos) begin
               // checksum byte closes the record
               emit                     = 1'b1;
               rsp_word_in.kind         = KIND_END;
               rsp_word_in.byte_address = address_ff;
               rsp_word_in.record_type  = type_ff;
               rsp_word_in.byte_count   = length_ff;
               rsp_word_in.checksum_ok  = ((8'd0 - sum_ff) == byte_val);
               rsp_word_in.too_long     = (length_ff > MAX_DATA);
               in_record_in             = 1'b0;
               pos_in                   = POS_COUNT;
            end else begin
               sum_in = sum_ff + byte_val;
               pos_in = pos_ff + 1'b1;
               case (pos_ff)
                  POS_COUNT:   length_in = byte_val;
                  POS_ADDR_HI: address_in = {byte_val, address_ff[7:0]};
                  POS_ADDR_LO: address_in = {address_ff[15:8], byte_val};
                  POS_TYPE:    type_in = byte_val;
                  default: begin
                     emit                     = 1'b1;
                     rsp_word_in.kind         = KIND_DATA;
                     rsp_word_in.byte_address = address_ff + {7'd0, data_offset};
                     rsp_word_in.data_byte    = byte_val;
                  end
               endcase
            end
         end
      end
   end

   // register next values
   always_comb begin
      in_char_in = req_take ? req_if.character : in_char_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && !rsp_if.ready);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         in_record_ff   <= 1'b0;
         low_next_ff    <= 1'b0;
         high_nibble_ff <= '0;
         pos_ff         <= '0;
         length_ff      <= '0;
         address_ff     <= '0;
         type_ff        <= '0;
         sum_ff         <= '0;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         in_record_ff   <= in_record_in;
         low_next_ff    <= low_next_in;
         high_nibble_ff <= high_nibble_in;
         pos_ff         <= pos_in;
         length_ff      <= length_in;
         address_ff     <= address_in;
         type_ff        <= type_in;
         sum_ff         <= sum_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_char_ff <= in_char_in;
      if (emit) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // result channel
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.kind         = rsp_word_ff.kind;
   assign rsp_if.byte_address = rsp_word_ff.byte_address;
   assign rsp_if.data_byte    = rsp_word_ff.data_byte;
   assign rsp_if.record_type  = rsp_word_ff.record_type;
   assign rsp_if.byte_count   = rsp_word_ff.byte_count;
   assign rsp_if.checksum_ok  = rsp_word_ff.checksum_ok;
   assign rsp_if.too_long     = rsp_word_ff.too_long;

endmodule

### dv/hex_record_receiver_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hex_record_receiver_top_tb
// drives ascii characters into the hex record receiver and checks every
// result word against a cycle-free predictor of the record decoder
// ----------------------------------------------------------------------------
module hex_record_receiver_top_tb;
   import hrr_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned RANDOM_CHARS = 1950;
   localparam int unsigned DRAIN_CYCLES = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hrr_req_if req_if ();
   hrr_rsp_if rsp_if ();

   hex_record_receiver_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #5 clock = ~clock;

   // characters waiting to be sent, front is the one on the bus
   logic [7:0]   char_queue[$];
   // result words the decoder must still produce, oldest first
   rsp_word_type expected_words[$];

   int unsigned total_chars;
   int unsigned accepted;
   int unsigned cycle_count;
   int unsigned errors;
   int unsigned data_seen;
   int unsigned end_seen;
   int unsigned bad_sum_seen;
   int unsigned overlong_seen;
   logic        req_took;

   // predictor copy of the decoder state
   logic             rec_open;
   logic             want_low;
   logic [3:0]       held_nibble;
   logic [POS_W-1:0] rec_pos;
   logic [7:0]       rec_len;
   logic [15:0]      rec_addr;
   logic [7:0]       rec_type;
   logic [7:0]       rec_sum;

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   // value of one hex digit, all ones for anything else
   function automatic logic [7:0] hex_value(input logic [7:0] ch);
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) return ch - CHAR_ZERO;
      if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_F) return ch - CHAR_LOWER_A + DIGIT_TEN;
      if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_F) return ch - CHAR_UPPER_A + DIGIT_TEN;
      return DIGIT_BAD;
   endfunction

   // advance the record state by one accepted character, queue any result
   function automatic void decode_character(input logic [7:0] ch);
      logic [7:0]       v;
      logic [7:0]       b;
      logic [7:0]       neg_sum;
      logic [POS_W-1:0] last;
      rsp_word_type     w;
      w = '0;
      if (!rec_open) begin
         // idle: only a colon matters
         if (ch == CHAR_COLON) begin
            rec_open = 1'b1;
            want_low = 1'b0;
            rec_pos  = '0;
            rec_sum  = '0;
         end
         return;
      end
      v = hex_value(ch);
      if (!want_low) begin
         // bad high digit keeps its low four bits
         held_nibble = v[3:0];
         want_low    = 1'b1;
         return;
      end
      want_low = 1'b0;
      // bad low digit forces the whole byte to all ones
      b    = {held_nibble, 4'h0} | v;
      last = POS_W'(rec_len) + POS_DATA;
      if (rec_pos >= POS_DATA && rec_pos == last) begin
         // checksum byte closes the record
         neg_sum          = 8'd0 - rec_sum;
         w.kind           = KIND_END;
         w.byte_address   = rec_addr;
         w.record_type    = rec_type;
         w.byte_count     = rec_len;
         w.checksum_ok    = (neg_sum == b);
         w.too_long       = (rec_len > MAX_DATA);
         expected_words.push_back(w);
         rec_open = 1'b0;
         rec_pos  = '0;
         return;
      end
      rec_sum = rec_sum + b;
      case (rec_pos)
         POS_COUNT:   rec_len = b;
         POS_ADDR_HI: rec_addr[15:8] = b;
         POS_ADDR_LO: rec_addr[7:0] = b;
         POS_TYPE:    rec_type = b;
         default: begin
            // data byte, address wraps at 16 bits
            w.kind         = KIND_DATA;
            w.byte_address = rec_addr + 16'(rec_pos - POS_DATA);
            w.data_byte    = b;
            expected_words.push_back(w);
         end
      endcase
      rec_pos = rec_pos + 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++) char_queue.push_back(s[i]);
   endfunction

   // one nibble as a hex digit, letters in either case
   function automatic logic [7:0] nibble_char(input logic [3:0] n);
      if (n < 4'd10) return CHAR_ZERO + 8'(n);
      if ($urandom_range(0, 1)) return CHAR_UPPER_A + 8'(n) - DIGIT_TEN;
      return CHAR_LOWER_A + 8'(n) - DIGIT_TEN;
   endfunction

   function automatic void push_byte(input logic [7:0] b);
      char_queue.push_back(nibble_char(b[7:4]));
      char_queue.push_back(nibble_char(b[3:0]));
   endfunction

   // any character that is not a hex digit, colon included
   function automatic logic [7:0] junk_char();
      logic [7:0] c;
      c = 8'(($urandom_range(0, 3) == 0) ? CHAR_COLON : $urandom_range(0, 255));
      while (hex_value(c) != DIGIT_BAD) c = 8'($urandom_range(0, 255));
      return c;
   endfunction

   // one record: well-formed most of the time, optionally with a wrong
   // checksum, a corrupted digit or cut short; returns characters pushed
   function automatic int unsigned push_record(input logic [7:0] count);
      int unsigned start;
      int unsigned n;
      logic [15:0] addr;
      logic [7:0]  rtype;
      logic [7:0]  sum;
      logic [7:0]  data;
      addr  = ($urandom_range(0, 4) == 0) ? {12'hFFF, 4'($urandom)} : 16'($urandom);
      rtype = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 5)) : 8'($urandom);
      start = char_queue.size();
      char_queue.push_back(CHAR_COLON);
      push_byte(count);
      push_byte(addr[15:8]);
      push_byte(addr[7:0]);
      push_byte(rtype);
      sum = count + addr[15:8] + addr[7:0] + rtype;
      for (int i = 0; i < count; i++) begin
         data = 8'($urandom);
         push_byte(data);
         sum = sum + data;
      end
      if ($urandom_range(0, 3) == 0) push_byte(8'($urandom));
      else push_byte(8'd0 - sum);
      n = char_queue.size() - start;
      // corrupted digit somewhere inside the record
      if ($urandom_range(0, 9) == 0)
         char_queue[start + $urandom_range(1, n - 1)] = junk_char();
      // cut short, the following characters land inside the record
      if ($urandom_range(0, 24) == 0) begin
         repeat ($urandom_range(1, n - 1)) void'(char_queue.pop_back());
         n = char_queue.size() - start;
      end
      return n;
   endfunction

   // ---------------------------------------------------------------------
   // idling phases: none, sender gaps, receiver stalls, both light
   // ---------------------------------------------------------------------

   function automatic int unsigned phase_now();
      if (total_chars == 0) return 0;
      return (accepted * 4) / total_chars;
   endfunction

   function automatic int unsigned gap_pct();
      case (phase_now())
         1:       return 47;
         3:       return 9;
         default: return 0;
      endcase
   endfunction

   function automatic int unsigned stall_pct();
      case (phase_now())
         2:       return 47;
         3:       return 9;
         default: return 0;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // driver: new word offered at the falling edge once the last one went
   // ---------------------------------------------------------------------

   initial begin
      req_if.valid     = 1'b0;
      req_if.character = 8'h00;
      rsp_if.ready     = 1'b0;
      req_took         = 1'b0;
      rec_open         = 1'b0;
      want_low         = 1'b0;
      held_nibble      = '0;
      rec_pos          = '0;
      rec_len          = '0;
      rec_addr         = '0;
      rec_type         = '0;
      rec_sum          = '0;
   end

   // acceptance at the rising edge feeds the predictor
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         decode_character(req_if.character);
         void'(char_queue.pop_front());
         accepted++;
         req_took <= 1'b1;
      end else begin
         req_took <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_took) begin
         if (char_queue.size() > 0 && $urandom_range(0, 99) >= gap_pct()) begin
            req_if.valid     <= 1'b1;
            req_if.character <= char_queue[0];
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct());
   end

   // ---------------------------------------------------------------------
   // monitor: each result word against the oldest expected word
   // ---------------------------------------------------------------------

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      rsp_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_words.size() == 0) begin
            $error("result word with nothing expected: kind %0d address %0h",
                   rsp_if.kind, rsp_if.byte_address);
            errors++;
         end else begin
            want = expected_words.pop_front();
            check_field("kind", want.kind, rsp_if.kind);
            check_field("byte_address", want.byte_address, rsp_if.byte_address);
            check_field("data_byte", want.data_byte, rsp_if.data_byte);
            check_field("record_type", want.record_type, rsp_if.record_type);
            check_field("byte_count", want.byte_count, rsp_if.byte_count);
            check_field("checksum_ok", want.checksum_ok, rsp_if.checksum_ok);
            check_field("too_long", want.too_long, rsp_if.too_long);
            if (want.kind == KIND_END) begin
               end_seen++;
               if (!want.checksum_ok) bad_sum_seen++;
               if (want.too_long) overlong_seen++;
            end else begin
               data_seen++;
            end
         end
      end
   end

   // hard stop if the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("hex_record_receiver_top_tb failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------------

   initial begin : stimulus
      int unsigned record_chars;
      logic [7:0]  count;
      int unsigned pick;

      // idle noise at both ends of the byte range, dropped by the block
      char_queue.push_back(8'h00);
      char_queue.push_back(8'hFF);
      // zero count at the top address, good checksum
      push_text(":00FFFF0101");
      // bad high digits, colon inside a record, mixed case, bad checksum
      push_text(":01g00:00aFx5");

      // one record at the largest count, then random records
      record_chars = push_record(8'd255);
      while (record_chars < RANDOM_CHARS) begin
         repeat ($urandom_range(0, 2)) char_queue.push_back(8'($urandom));
         pick = $urandom_range(0, 99);
         if (pick < 85)      count = 8'($urandom_range(0, MAX_DATA));
         else if (pick < 97) count = 8'($urandom_range(MAX_DATA + 1, 40));
         else                count = 8'($urandom_range(41, 255));
         record_chars += push_record(count);
      end
      // trailing noise, also closes any record cut short at the end
      repeat (4) char_queue.push_back(8'($urandom));
      total_chars = char_queue.size();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // every character taken, then every result seen
      while (char_queue.size() > 0 || expected_words.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d characters; checked %0d data words and %0d record ends",
               accepted, data_seen, end_seen);
      $display("record ends with bad checksum %0d, overlong %0d", bad_sum_seen, overlong_seen);
      if (errors == 0) begin
         $display("hex_record_receiver_top_tb passed");
      end else begin
         $display("hex_record_receiver_top_tb failed");
      end
      $finish;
   end

endmodule
